/* src/lvc_pkg.sv */
// Shared types and constants for the landing velocity controller.
// Used by lvc_cfg_regs, lvc_law and landing_velocity_controller; no dependencies.
package lvc_pkg;

  // Q3.12 fixed point: 4096 = 1.0
  localparam int unsigned POSE_W     = 16;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LAT_VEL_W  = 14;
  localparam int unsigned VERT_VEL_W = 13;
  localparam int unsigned S_DATA_W   = 64;
  localparam int unsigned M_DATA_W   = 56;

  localparam logic signed [POSE_W-1:0] LATERAL_GATE_Q = 16'sd2048;  // 0.5
  localparam logic [10:0]              DESCENT_FAST_Q = 11'd1229;   // 0.3
  localparam logic [10:0]              DESCENT_SLOW_Q = 11'd410;    // 0.1
  localparam logic [13:0]              LAT_LIMIT_Q    = 14'd4096;   // 1.0
  localparam logic [13:0]              VERT_LIMIT_Q   = 14'd2048;   // 0.5

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATERAL_THRESHOLD = 3'd0,
    CFG_YAW_THRESHOLD     = 3'd1,
    CFG_START_HEIGHT      = 3'd2,
    CFG_FINAL_HEIGHT      = 3'd3,
    CFG_GAIN_LATERAL      = 3'd4,
    CFG_GAIN_VERTICAL     = 3'd5,
    CFG_GAIN_HEADING      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] lateral_threshold;
    logic [CFG_W-1:0] yaw_threshold;
    logic [CFG_W-1:0] start_height;
    logic [CFG_W-1:0] final_height;
    logic [CFG_W-1:0] gain_lateral;
    logic [CFG_W-1:0] gain_vertical;
    logic [CFG_W-1:0] gain_heading;
  } cfg_t;

  typedef struct packed {
    logic signed [POSE_W-1:0] offset_right;
    logic signed [POSE_W-1:0] offset_down;
    logic signed [POSE_W-1:0] height;
    logic signed [POSE_W-1:0] heading_error;
  } pose_t;

  typedef struct packed {
    logic                         land_now;
    logic signed [LAT_VEL_W-1:0]  vel_forward;
    logic signed [LAT_VEL_W-1:0]  vel_right;
    logic signed [VERT_VEL_W-1:0] vel_vertical;
    logic signed [VERT_VEL_W-1:0] turn_rate;
  } result_t;

endpackage

/* src/lvc_cfg_regs.sv */
// Configuration register file for the landing velocity controller.
// Depends on lvc_pkg (cfg_t, cfg_idx_t).
module lvc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lvc_pkg::CFG_IDX_W-1:0]  index,
  input  logic [lvc_pkg::CFG_W-1:0]      wr_data,
  output lvc_pkg::cfg_t                  cfg
);
  import lvc_pkg::*;

  cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lateral_threshold <= 15'd205;
      regs.yaw_threshold     <= 15'd410;
      regs.start_height      <= 15'd8192;
      regs.final_height      <= 15'd1229;
      regs.gain_lateral      <= 15'd3277;
      regs.gain_vertical     <= 15'd1638;
      regs.gain_heading      <= 15'd2048;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(index))
        CFG_LATERAL_THRESHOLD: regs.lateral_threshold <= wr_data;
        CFG_YAW_THRESHOLD:     regs.yaw_threshold     <= wr_data;
        CFG_START_HEIGHT:      regs.start_height      <= wr_data;
        CFG_FINAL_HEIGHT:      regs.final_height      <= wr_data;
        CFG_GAIN_LATERAL:      regs.gain_lateral      <= wr_data;
        CFG_GAIN_VERTICAL:     regs.gain_vertical     <= wr_data;
        CFG_GAIN_HEADING:      regs.gain_heading      <= wr_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

endmodule

/* src/lvc_law.sv */
// Control law: gated proportional terms, rounding, saturation and land decision.
// Pure combinational; depends on lvc_pkg (pose_t, cfg_t, result_t, constants).
module lvc_law (
  input  lvc_pkg::pose_t   pose,
  input  lvc_pkg::cfg_t    cfg,
  output lvc_pkg::result_t result
);
  import lvc_pkg::*;

  // Round Q6.24 to Q3.12, ties toward plus infinity, then clamp to +-lim
  function automatic logic signed [13:0] round_sat(input logic signed [32:0] p,
                                                   input logic [13:0] lim);
    logic signed [32:0] r;
    logic signed [32:0] lim_s;
    r     = (p + 33'sd2048) >>> 12;
    lim_s = $signed({19'd0, lim});
    if (r > lim_s) begin
      round_sat = lim_s[13:0];
    end else if (r < -lim_s) begin
      round_sat = 14'(-lim_s);
    end else begin
      round_sat = r[13:0];
    end
  endfunction

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = {v[15], v};
    abs17 = w[16] ? 17'(-w) : 17'(w);
  endfunction

  function automatic logic signed [16:0] neg17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = {v[15], v};
    neg17 = -w;
  endfunction

  logic [16:0]        abs_right, abs_down, abs_heading;
  logic               lateral_on, turn_on, above_final, centered;
  logic signed [32:0] prod_fwd, prod_right, prod_turn;
  logic [10:0]        descent_q;
  logic [25:0]        prod_vert;
  logic [14:0]        vert_round;
  logic signed [13:0] vel_fwd_sat, vel_right_sat, turn_sat;
  logic signed [12:0] vert_sat;

  always_comb begin
    abs_right   = abs17(pose.offset_right);
    abs_down    = abs17(pose.offset_down);
    abs_heading = abs17(pose.heading_error);

    lateral_on  = pose.height > LATERAL_GATE_Q;
    turn_on     = abs_heading > {2'b00, cfg.yaw_threshold};
    above_final = $signed({pose.height[15], pose.height}) >
                  $signed({2'b00, cfg.final_height});
    centered    = (abs_right < {2'b00, cfg.lateral_threshold}) &&
                  (abs_down < {2'b00, cfg.lateral_threshold}) &&
                  (abs_heading < {2'b00, cfg.yaw_threshold});

    // Forward follows the marker's downward offset, right follows its right offset
    prod_fwd   = 33'($signed({1'b0, cfg.gain_lateral}) * neg17(pose.offset_down));
    prod_right = 33'($signed({1'b0, cfg.gain_lateral}) * neg17(pose.offset_right));
    prod_turn  = 33'($signed({1'b0, cfg.gain_heading}) * neg17(pose.heading_error));

    descent_q  = above_final ? DESCENT_FAST_Q : DESCENT_SLOW_Q;
    prod_vert  = 26'(cfg.gain_vertical) * 26'(descent_q);
    vert_round = 15'((prod_vert + 26'd2048) >> 12);

    vel_fwd_sat   = lateral_on ? round_sat(prod_fwd, LAT_LIMIT_Q) : '0;
    vel_right_sat = lateral_on ? round_sat(prod_right, LAT_LIMIT_Q) : '0;
    turn_sat      = turn_on ? round_sat(prod_turn, VERT_LIMIT_Q) : '0;

    // Descent is always downward: negate the rounded magnitude and clamp
    if (vert_round > 15'(VERT_LIMIT_Q)) begin
      vert_sat = -$signed(13'(VERT_LIMIT_Q));
    end else begin
      vert_sat = 13'(-$signed({1'b0, vert_round}));
    end

    if (centered && !above_final) begin
      result.land_now     = 1'b1;
      result.vel_forward  = '0;
      result.vel_right    = '0;
      result.vel_vertical = '0;
      result.turn_rate    = '0;
    end else begin
      result.land_now     = 1'b0;
      result.vel_forward  = vel_fwd_sat;
      result.vel_right    = vel_right_sat;
      result.vel_vertical = vert_sat;
      result.turn_rate    = turn_sat[12:0];
    end
  end

endmodule

/* src/landing_velocity_controller.sv */
// Top level of the landing velocity controller: stream ports, pose register,
// landing latch and result register. Depends on lvc_pkg, lvc_cfg_regs, lvc_law.
//
// Usage:
//   A pose word enters on the s_ channel (s_tvalid/s_tready). Each kept pose
//   yields one result word on the m_ channel (m_tvalid/m_tready): tuser carries
//   land_now, tdata the four velocity setpoints.
//   A pose higher than start_height is dropped with no result until landing
//   mode has latched; the first pose at or below start_height latches it, and
//   from then on every pose gives a result.
//   From acceptance to m_tvalid a pose passes the pose register, then the
//   control law (three parallel 16x17 multiplies, round and clamp) into the
//   result register. The block takes one word per cycle while the receiver
//   keeps up; a stall holds the flow as described below.
//   When the receiver stalls, the result register holds and the pose register
//   still takes one more word; s_tready falls only when both are full.
//   Synchronous reset clears both valid flags and the landing latch and loads
//   the default register values. Write configuration through cfg_wr_en,
//   cfg_index and cfg_wr_data only while the block is idle.
module landing_velocity_controller (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [lvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lvc_pkg::CFG_W-1:0]           cfg_wr_data,
  // pose input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] offset_right, [31:16] offset_down, [47:32] height, [63:48] heading_error
  input  logic [lvc_pkg::S_DATA_W-1:0]        s_tdata,
  // result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [13:0] vel_forward, [27:14] vel_right, [40:28] vel_vertical,
  // [53:41] turn_rate, [55:54] zero
  output logic [lvc_pkg::M_DATA_W-1:0]        m_tdata,
  // [0] land_now
  output logic                                m_tuser
);
  import lvc_pkg::*;

  cfg_t    cfg;
  pose_t   pose_in;
  pose_t   pose;
  result_t law_out;
  result_t result;
  logic    pose_valid;
  logic    landing_active;
  logic    keep_in;
  logic    accept;
  logic    advance;

  lvc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .index   (cfg_index),
    .wr_data (cfg_wr_data),
    .cfg     (cfg)
  );

  assign pose_in.offset_right  = s_tdata[15:0];
  assign pose_in.offset_down   = s_tdata[31:16];
  assign pose_in.height        = s_tdata[47:32];
  assign pose_in.heading_error = s_tdata[63:48];

  // Keep the pose once latched, or when it is at or below the start height
  assign keep_in = landing_active ||
                   !($signed({pose_in.height[15], pose_in.height}) >
                     $signed({2'b00, cfg.start_height}));

  // Result register free, or being emptied this cycle
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !pose_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      landing_active <= 1'b0;
      pose_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept && keep_in) begin
        landing_active <= 1'b1;
      end
      if (s_tready) begin
        pose_valid <= accept && keep_in;
      end
      if (advance) begin
        m_tvalid <= pose_valid;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      pose <= pose_in;
    end
    if (advance && pose_valid) begin
      result <= law_out;
    end
  end

  lvc_law u_law (
    .pose   (pose),
    .cfg    (cfg),
    .result (law_out)
  );

  assign m_tuser = result.land_now;
  assign m_tdata = {2'b00, result.turn_rate, result.vel_vertical,
                    result.vel_right, result.vel_forward};

endmodule

/* bench/lvc_checker.sv */
// Checker for the landing velocity controller: watches the config, pose and command channels,
// predicts each command word and compares it field by field. Depends on lvc_pkg.
`timescale 1ns / 1ps
module lvc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lvc_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // [15:0] offset_right, [31:16] offset_down, [47:32] height, [63:48] heading_error
  input  logic [lvc_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [13:0] vel_forward, [27:14] vel_right, [40:28] vel_vertical, [53:41] turn_rate,
  // [55:54] zero
  input  logic [lvc_pkg::M_DATA_W-1:0]  m_tdata,
  // [0] land_now
  input  logic                          m_tuser,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            lands_seen
);
  import lvc_pkg::*;

  localparam int VF_LSB  = 0;
  localparam int VR_LSB  = VF_LSB + LAT_VEL_W;
  localparam int VV_LSB  = VR_LSB + LAT_VEL_W;
  localparam int TR_LSB  = VV_LSB + VERT_VEL_W;
  localparam int PAD_LSB = TR_LSB + VERT_VEL_W;
  localparam int PAD_W   = M_DATA_W - PAD_LSB;

  localparam longint LATERAL_GATE = 2048;  // 0.5 m
  localparam longint DESCENT_FAST = 1229;  // 0.3
  localparam longint DESCENT_SLOW = 410;   // 0.1
  localparam longint LAT_LIMIT    = 4096;  // 1.0
  localparam longint VERT_LIMIT   = 2048;  // 0.5
  localparam int     MAX_PRINTED  = 20;

  // shadow of the register file and the landing latch
  longint lat_tol, yaw_tol, start_h, final_h, k_lat, k_vert, k_head;
  bit     landing;

  result_t cmd_queue[$];

  // Q6.24 to Q3.12, nearest with ties up
  function automatic longint q12_round(longint prod);
    return (prod + 2048) >>> 12;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Work out the command a pose word produces; returns 0 when the pose is dropped.
  function automatic bit predict_command(input logic [S_DATA_W-1:0] word, output result_t cmd);
    longint right, down, h, yaw;
    longint vf, vr, vv, tr;
    bit     centered;
    right = longint'($signed(word[0*POSE_W +: POSE_W]));
    down  = longint'($signed(word[1*POSE_W +: POSE_W]));
    h     = longint'($signed(word[2*POSE_W +: POSE_W]));
    yaw   = longint'($signed(word[3*POSE_W +: POSE_W]));
    cmd = '0;
    if (!landing) begin
      if (h > start_h) return 1'b0;
      landing = 1'b1;
    end
    vf = 0;
    vr = 0;
    tr = 0;
    if (h > LATERAL_GATE) begin
      vf = q12_round(k_lat * -down);
      vr = q12_round(k_lat * -right);
    end
    if (mag(yaw) > yaw_tol) tr = q12_round(k_head * -yaw);
    vv = (h > final_h) ? -q12_round(k_vert * DESCENT_FAST) : -q12_round(k_vert * DESCENT_SLOW);
    vf = clamp_to(vf, LAT_LIMIT);
    vr = clamp_to(vr, LAT_LIMIT);
    vv = clamp_to(vv, VERT_LIMIT);
    tr = clamp_to(tr, VERT_LIMIT);
    centered = mag(right) < lat_tol && mag(down) < lat_tol && mag(yaw) < yaw_tol;
    if (centered && h <= final_h) begin
      cmd.land_now = 1'b1;
    end else begin
      cmd.vel_forward  = vf[LAT_VEL_W-1:0];
      cmd.vel_right    = vr[LAT_VEL_W-1:0];
      cmd.vel_vertical = vv[VERT_VEL_W-1:0];
      cmd.turn_rate    = tr[VERT_VEL_W-1:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    result_t cmd;
    result_t want;
    if (rst) begin
      lat_tol = 205;
      yaw_tol = 410;
      start_h = 8192;
      final_h = 1229;
      k_lat   = 3277;
      k_vert  = 1638;
      k_head  = 2048;
      landing = 1'b0;
      cmd_queue.delete();
      fail_count   = 0;
      results_seen = 0;
      lands_seen   = 0;
    end else begin
      // compare first: a word leaving now belongs to an older pose
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (cmd_queue.size() == 0) begin
          report_mismatch($sformatf("command word 0x%0h with nothing pending", m_tdata));
        end else begin
          want = cmd_queue.pop_front();
          if (want.land_now) lands_seen++;
          check_field("land_now", m_tuser, want.land_now);
          check_field("vel_forward", $signed(m_tdata[VF_LSB +: LAT_VEL_W]),
                      $signed(want.vel_forward));
          check_field("vel_right", $signed(m_tdata[VR_LSB +: LAT_VEL_W]),
                      $signed(want.vel_right));
          check_field("vel_vertical", $signed(m_tdata[VV_LSB +: VERT_VEL_W]),
                      $signed(want.vel_vertical));
          check_field("turn_rate", $signed(m_tdata[TR_LSB +: VERT_VEL_W]),
                      $signed(want.turn_rate));
          check_field("padding", m_tdata[PAD_LSB +: PAD_W], 0);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LATERAL_THRESHOLD: lat_tol = cfg_wr_data;
          CFG_YAW_THRESHOLD:     yaw_tol = cfg_wr_data;
          CFG_START_HEIGHT:      start_h = cfg_wr_data;
          CFG_FINAL_HEIGHT:      final_h = cfg_wr_data;
          CFG_GAIN_LATERAL:      k_lat   = cfg_wr_data;
          CFG_GAIN_VERTICAL:     k_vert  = cfg_wr_data;
          CFG_GAIN_HEADING:      k_head  = cfg_wr_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (predict_command(s_tdata, cmd)) cmd_queue.push_back(cmd);
      end
    end
    pending = cmd_queue.size();
  end

endmodule

/* bench/landing_velocity_controller_test.sv */
// Top of the landing velocity controller bench: clock, reset, pose stimulus, receiver
// back-pressure and verdict. Depends on lvc_pkg, lvc_checker and landing_velocity_controller.
`timescale 1ns / 1ps
module landing_velocity_controller_test;
  import lvc_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int RANDOM_PHASES   = 8;
  localparam int POSES_PER_PHASE = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  // pose register plus result register, with margin for a dropped pose in flight
  localparam int SETTLE_CYCLES   = 4;
  localparam int IDLE_PERCENT    = 11;
  localparam int CFG_MAX         = 32767;
  // index past the register list; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tuser;

  int fail_count, pending, results_seen, lands_seen;
  int cycles = 0;
  int poses_sent = 0;
  int settings_used = 0;

  // quiet: no idling on either side; hold_req/hold_done: one long receiver stall
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // stimulus-side copy of the thresholds, used only to aim poses at boundaries
  int cur_lat = 205, cur_yaw = 410, cur_start = 8192, cur_final = 1229;

  landing_velocity_controller uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  lvc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .lands_seen   (lands_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bail out if the run hangs: a missing command word never drains the queue.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d command words outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: drop tready at random on IDLE_PERCENT percent of cycles, except in quiet stretches.
  // Once asked, hold off for a long stretch so the pose register and result
  // register both fill and s_tready falls while the sender keeps offering.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // One register write; the bench only calls this while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data[CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LATERAL_THRESHOLD: cur_lat   = data;
      CFG_YAW_THRESHOLD:     cur_yaw   = data;
      CFG_START_HEIGHT:      cur_start = data;
      CFG_FINAL_HEIGHT:      cur_final = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(input int lat, input int yaw, input int start, input int fin,
                              input int k_lat, input int k_vert, input int k_head);
    write_reg(CFG_LATERAL_THRESHOLD, lat);
    write_reg(CFG_YAW_THRESHOLD, yaw);
    write_reg(CFG_START_HEIGHT, start);
    write_reg(CFG_FINAL_HEIGHT, fin);
    write_reg(CFG_GAIN_LATERAL, k_lat);
    write_reg(CFG_GAIN_VERTICAL, k_vert);
    write_reg(CFG_GAIN_HEADING, k_head);
    settings_used++;
  endtask

  // Offer one pose word; idle first at random, then hold tvalid until accepted.
  task automatic send_pose(input logic [POSE_W-1:0] right, input logic [POSE_W-1:0] down,
                           input logic [POSE_W-1:0] h, input logic [POSE_W-1:0] yaw);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {yaw, h, down, right};
    do @(posedge clk); while (!s_tready);
    poses_sent++;
  endtask

  // Stop offering, wait for every expected command word, then let any
  // dropped pose still in the pipeline clear out.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // value within +-spread of center, saturated to the pose field range
  function automatic logic [POSE_W-1:0] near(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[POSE_W-1:0];
  endfunction

  function automatic int either_sign(input int v);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  // Random pose aimed at the control law's boundaries half of the time.
  task automatic random_pose();
    logic [POSE_W-1:0] r, d, h, y;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // anything goes
        r = 16'($urandom);
        d = 16'($urandom);
        h = 16'($urandom);
        y = 16'($urandom);
      end
      3, 4: begin
        // height on a gate: final height, lateral gate or start height
        r = near(0, 8192);
        d = near(0, 8192);
        y = near(either_sign(cur_yaw), 3);
        case ($urandom_range(0, 2))
          0:       h = near(cur_final, 3);
          1:       h = near(2048, 3);
          default: h = near(cur_start, 3);
        endcase
      end
      5, 6, 7: begin
        // final approach: near or inside the centering window, low
        r = $urandom_range(0, 1) ? near(either_sign(cur_lat), 2) : near(0, cur_lat);
        d = $urandom_range(0, 1) ? near(either_sign(cur_lat), 2) : near(0, cur_lat);
        y = $urandom_range(0, 1) ? near(either_sign(cur_yaw), 2) : near(0, cur_yaw);
        h = $urandom_range(0, 1) ? near(cur_final, 3) : near(cur_final / 2, cur_final / 2 + 1);
      end
      default: begin
        r = near(0, 8192);
        d = near(0, 8192);
        h = near(0, 8192);
        y = near(0, 8192);
      end
    endcase
    send_pose(r, d, h, y);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Too high before landing mode: dropped with no command.
    send_pose(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
    send_pose(16'sd100, -16'sd100, 16'sd8193, 16'sd50);
    wait_drained();

    // Lowest start height: a positive height is still dropped, then a
    // negative height counts as low and latches landing mode.
    write_reg(CFG_START_HEIGHT, 0);
    send_pose(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_pose(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
    // full-scale offsets and heading: saturate the lateral and turn setpoints
    send_pose(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_pose(-16'sd32768, 16'sd32767, 16'sd2049, 16'sd32767);
    // exactly at the lateral gate: no lateral move; heading just past deadband
    send_pose(16'sd4096, 16'sd4096, 16'sd2048, 16'sd411);
    // just above final height, heading on the deadband edge
    send_pose(16'sd0, 16'sd0, 16'sd1230, 16'sd410);
    // land at final height and at the edges of the centering window
    send_pose(16'sd0, 16'sd0, 16'sd1229, 16'sd0);
    send_pose(16'sd204, -16'sd204, 16'sd1229, 16'sd409);
    // offsets or heading on the tolerance: not centered, slow descent
    send_pose(16'sd205, 16'sd0, 16'sd0, 16'sd0);
    send_pose(16'sd0, -16'sd205, 16'sd0, 16'sd0);
    send_pose(16'sd0, 16'sd0, 16'sd0, -16'sd410);
    send_pose(16'sd0, 16'sd0, 16'sd0, -16'sd411);
    wait_drained();

    // Out-of-range index must be ignored; then gains of 0.5 put products on
    // rounding ties in both directions.
    write_reg(CFG_UNUSED_IDX, CFG_MAX);
    load_setting(205, 410, 0, 1229, 2048, 2048, 2048);
    send_pose(16'sd1, -16'sd1, 16'sd4096, 16'sd3000);
    send_pose(16'sd3, -16'sd3, 16'sd4096, -16'sd411);
    send_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_setting(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        1: load_setting(0, 0, 0, 0, 0, 0, 0);
        2: load_setting(205, 410, 8192, 1229, 3277, 1638, 2048);
        default: begin
          if (phase % 2)
            load_setting($urandom_range(0, CFG_MAX), $urandom_range(0, CFG_MAX),
                         $urandom_range(0, CFG_MAX), $urandom_range(0, CFG_MAX),
                         $urandom_range(0, CFG_MAX), $urandom_range(0, CFG_MAX),
                         $urandom_range(0, CFG_MAX));
          else
            load_setting($urandom_range(0, 2047), $urandom_range(0, 2047),
                         $urandom_range(0, CFG_MAX), $urandom_range(0, 8191),
                         $urandom_range(0, CFG_MAX), $urandom_range(0, CFG_MAX),
                         $urandom_range(0, CFG_MAX));
        end
      endcase
      quiet = (phase == 3);
      for (n = 0; n < POSES_PER_PHASE; n++) begin
        if (phase == 2 && n == 20) hold_req = 1'b1;
        // pause the sender until every command word is back
        if (phase == 4 && n == 100) wait_drained();
        random_pose();
      end
      wait_drained();
      quiet = 1'b0;
    end

    $display("Sent %0d poses over %0d register settings; %0d command words checked,",
             poses_sent, settings_used, results_seen);
    $display("%0d of them land commands, with one long receiver stall.", lands_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
